// ===== rtl/bb4_pkg.sv =====
// Shared constants, types and helper functions of the 4x4 clipped box blur.
package bb4_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int CFG_W   = 11;
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 12;
  localparam int NUM_W   = 15;
  localparam int CNT_W   = 5;
  localparam int RCP_W   = 23;
  localparam int RCP_SHIFT = 22;
  localparam int PROD_W  = NUM_W + RCP_W;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // One window column as it travels from the front end to the back end.
  typedef struct packed {
    logic [3:0][PIX_W-1:0] col;
    logic [3:0]            col_ok;
    logic [3:0]            row_ok;
    logic                  gen_left;
    logic                  gen_last;
    logic                  last_row;
  } entry_t;

  // ceil(2^22 / (5*cnt + 1)); exact for every numerator up to 5*16*255.
  function automatic logic [RCP_W-1:0] rcp(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] v;
    begin
      case (cnt)
        5'd0:  v = 23'd4194304;
        5'd1:  v = 23'd699051;
        5'd2:  v = 23'd381301;
        5'd3:  v = 23'd262144;
        5'd4:  v = 23'd199729;
        5'd5:  v = 23'd161320;
        5'd6:  v = 23'd135301;
        5'd7:  v = 23'd116509;
        5'd8:  v = 23'd102301;
        5'd9:  v = 23'd91181;
        5'd10: v = 23'd82242;
        5'd11: v = 23'd74899;
        5'd12: v = 23'd68760;
        5'd13: v = 23'd63551;
        5'd14: v = 23'd59075;
        5'd15: v = 23'd55189;
        5'd16: v = 23'd51782;
        default: v = 23'd4194304;
      endcase
      return v;
    end
  endfunction

  // Remainder by three: base-4 digits are summed, since 4 is 1 mod 3.
  function automatic logic [1:0] mod3(input logic [ROW_W-1:0] v);
    logic [ROW_W+1:0] p;
    int s;
    begin
      p = {2'b00, v};
      s = 0;
      for (int i = 0; i < (ROW_W + 2) / 2; i++) begin
        s = s + int'(p[2*i +: 2]);
      end
      for (int j = 0; j < 4; j++) begin
        s = (s & 3) + (s >> 2);
      end
      if (s >= 3) begin
        s = s - 3;
      end
      return 2'(s);
    end
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

// ===== rtl/bb4_if.sv =====
// Request channels of the blur: pixel input and blurred pixel output.
interface bb4_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_pixel;
  logic        is_pad;
  modport source (output valid, output in_pixel, output is_pad, input ready);
  modport sink (input valid, input in_pixel, input is_pad, output ready);
endinterface

interface bb4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        end_of_run;
  logic        end_of_frame;
  modport source (output valid, output out_pixel, output end_of_run, output end_of_frame,
                  input ready);
  modport sink (input valid, input out_pixel, input end_of_run, input end_of_frame,
                output ready);
endinterface

// ===== rtl/bb4_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module bb4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bb4_front.sv =====
// Front end: configuration, position counters, row store and window column fetch.
module bb4_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bb4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb4_pkg::CFG_W-1:0]      cfg_data,
  bb4_in_if.sink                         in,
  input  logic [bb4_pkg::LVL_W-1:0]      level,
  output logic                           push,
  output bb4_pkg::entry_t                push_data
);

  logic [bb4_pkg::CFG_W-1:0] frame_width;
  logic [bb4_pkg::CFG_W-1:0] frame_height;
  logic [bb4_pkg::COL_W-1:0] column_count;
  logic [bb4_pkg::ROW_W-1:0] row_count;

  logic [bb4_pkg::WID_W-1:0] w;
  logic [bb4_pkg::ROW_W-1:0] h;
  logic [bb4_pkg::COL_W-1:0] c;
  logic [bb4_pkg::ROW_W-1:0] r;
  logic [1:0]                slot;
  logic                      row_in;
  logic                      accept;
  logic                      col_last;
  logic [bb4_pkg::PIX_W-1:0] cur;
  logic [bb4_pkg::PIX_W-1:0] rdata [3];

  logic                      s1_valid;
  logic [bb4_pkg::PIX_W-1:0] s1_cur;
  logic [1:0]                s1_slot;
  logic [3:0]                s1_col_ok;
  logic [3:0]                s1_row_ok;
  logic                      s1_gen_left;
  logic                      s1_gen_last;
  logic                      s1_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb4_pkg::CFG_W'(640);
      frame_height <= bb4_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        bb4_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bb4_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < bb4_pkg::CFG_W'(2)) begin
      w = bb4_pkg::WID_W'(2);
    end else if (32'(frame_width) > bb4_pkg::MAX_WIDTH) begin
      w = bb4_pkg::WID_W'(bb4_pkg::MAX_WIDTH);
    end else begin
      w = bb4_pkg::WID_W'(frame_width);
    end
    if (frame_height < bb4_pkg::CFG_W'(2)) begin
      h = bb4_pkg::ROW_W'(2);
    end else if (32'(frame_height) > bb4_pkg::MAX_HEIGHT) begin
      h = bb4_pkg::ROW_W'(bb4_pkg::MAX_HEIGHT);
    end else begin
      h = bb4_pkg::ROW_W'(frame_height);
    end
  end

  // Counters left beyond a shrunken frame are pulled back inside it.
  assign c = (bb4_pkg::WID_W'(column_count) < w) ? column_count
                                                  : bb4_pkg::COL_W'(w - bb4_pkg::WID_W'(1));
  assign r        = (row_count < h) ? row_count : h;
  assign slot     = bb4_pkg::mod3(r);
  assign row_in   = (r < h);
  assign col_last = (bb4_pkg::WID_W'(c) == w - bb4_pkg::WID_W'(1));
  assign cur      = row_in ? in.in_pixel[31:8] : '0;

  assign in.ready = (bb4_pkg::LVL_W'(level) + bb4_pkg::LVL_W'(s1_valid))
                    < bb4_pkg::LVL_W'(bb4_pkg::FIFO_DEPTH);
  assign accept   = in.valid && in.ready;

  for (genvar b = 0; b < 3; b++) begin : g_bank
    bb4_ram #(.WIDTH(bb4_pkg::PIX_W), .DEPTH(bb4_pkg::MAX_WIDTH)) u_bank (
      .clk   (clk),
      .we    (accept && row_in && (slot == 2'(b))),
      .waddr (c),
      .wdata (cur),
      .raddr (c),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col_last) begin
          column_count <= '0;
          row_count    <= (r == h) ? '0 : r + bb4_pkg::ROW_W'(1);
        end else begin
          column_count <= c + bb4_pkg::COL_W'(1);
          row_count    <= r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur      <= cur;
      s1_slot     <= slot;
      s1_col_ok   <= {c >= bb4_pkg::COL_W'(3), c >= bb4_pkg::COL_W'(2),
                      c >= bb4_pkg::COL_W'(1), 1'b1};
      s1_row_ok   <= {row_in, r >= bb4_pkg::ROW_W'(1), r >= bb4_pkg::ROW_W'(2),
                      r >= bb4_pkg::ROW_W'(3)};
      s1_gen_left <= (r >= bb4_pkg::ROW_W'(1)) && (c >= bb4_pkg::COL_W'(1));
      s1_gen_last <= (r >= bb4_pkg::ROW_W'(1)) && col_last;
      s1_last_row <= (r == h);
    end
  end

  // Bank slot holds the row three back, the next slot two back, then one back.
  assign push = s1_valid;
  always_comb begin
    push_data.col[0]  = rdata[s1_slot];
    push_data.col[1]  = rdata[bb4_pkg::slot_inc(s1_slot)];
    push_data.col[2]  = rdata[bb4_pkg::slot_inc(bb4_pkg::slot_inc(s1_slot))];
    push_data.col[3]  = s1_cur;
    push_data.col_ok  = s1_col_ok;
    push_data.row_ok  = s1_row_ok;
    push_data.gen_left = s1_gen_left;
    push_data.gen_last = s1_gen_last;
    push_data.last_row = s1_last_row;
  end

endmodule

// ===== rtl/bb4_fifo.sv =====
// Short queue of window columns between the front end and the back end.
module bb4_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bb4_pkg::entry_t            push_data,
  input  logic                       pop,
  output bb4_pkg::entry_t            pop_data,
  output logic                       nonempty,
  output logic [bb4_pkg::LVL_W-1:0]  level
);

  bb4_pkg::entry_t              mem [bb4_pkg::FIFO_DEPTH];
  logic [bb4_pkg::PTR_W-1:0]    wptr;
  logic [bb4_pkg::PTR_W-1:0]    rptr;

  assign nonempty = (level != '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + bb4_pkg::PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + bb4_pkg::PTR_W'(1);
      end
      level <= level + bb4_pkg::LVL_W'(push) - bb4_pkg::LVL_W'(pop);
    end
  end

endmodule

// ===== rtl/bb4_back.sv =====
// Back end: 4x4 window, clipped sums, reciprocal division and output register.
module bb4_back (
  input  logic             clk,
  input  logic             rst,
  input  bb4_pkg::entry_t  pop_data,
  input  logic             nonempty,
  output logic             pop,
  bb4_out_if.source        out
);

  logic [bb4_pkg::PIX_W-1:0] win [4][4];

  logic       job_valid;
  logic       pend_a;
  logic       pend_b;
  logic [3:0] job_col_ok;
  logic [3:0] job_row_ok;
  logic       job_last_row;

  logic adv;
  logic issue;
  logic free;
  logic [15:0] use_mask;
  logic [bb4_pkg::SUM_W-1:0] sum [3];
  logic [bb4_pkg::NUM_W-1:0] num [3];

  logic                      st_valid;
  logic [bb4_pkg::NUM_W-1:0] st_num [3];
  logic [bb4_pkg::CNT_W-1:0] st_cnt;
  logic                      st_eor;
  logic                      st_eof;
  logic [bb4_pkg::RCP_W-1:0] st_rcp;
  logic [bb4_pkg::PROD_W-1:0] prod [3];

  assign adv   = !out.valid || out.ready;
  assign issue = job_valid && adv && (pend_a || pend_b);
  assign free  = !job_valid || !(issue ? (pend_a && pend_b) : (pend_a || pend_b));
  assign pop   = nonempty && free;

  // The left result spans four columns; the extra row-end result drops the oldest.
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int k = 0; k < 4; k++) begin
        use_mask[a*4 + k] = job_col_ok[a] && job_row_ok[k] && ((a != 3) || pend_a);
      end
    end
  end

  always_comb begin
    logic [bb4_pkg::SUM_W-1:0] colsum [4];
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 4; a++) begin
        colsum[a] = '0;
        for (int k = 0; k < 4; k++) begin
          if (use_mask[a*4 + k]) begin
            colsum[a] = colsum[a] + bb4_pkg::SUM_W'(win[a][k][(2-ch)*8 +: 8]);
          end
        end
      end
      sum[ch] = (colsum[0] + colsum[1]) + (colsum[2] + colsum[3]);
      num[ch] = {sum[ch], 2'b00} + bb4_pkg::NUM_W'(sum[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
    end else if (pop) begin
      job_valid <= 1'b1;
      pend_a    <= pop_data.gen_left;
      pend_b    <= pop_data.gen_last;
    end else if (free) begin
      job_valid <= 1'b0;
    end else if (issue) begin
      pend_a <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int a = 1; a < 4; a++) begin
        win[a] <= win[a-1];
      end
      for (int k = 0; k < 4; k++) begin
        win[0][k] <= pop_data.col[k];
      end
      job_col_ok   <= pop_data.col_ok;
      job_row_ok   <= pop_data.row_ok;
      job_last_row <= pop_data.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= 1'b0;
      out.valid <= 1'b0;
    end else if (adv) begin
      st_valid  <= issue;
      out.valid <= st_valid;
    end
  end

  assign st_rcp = bb4_pkg::rcp(st_cnt);
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bb4_pkg::PROD_W'(st_num[ch]) * bb4_pkg::PROD_W'(st_rcp);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        st_num[ch] <= num[ch];
      end
      st_cnt <= bb4_pkg::CNT_W'($countones(use_mask));
      st_eor <= !(pend_a && pend_b);
      st_eof <= !pend_a && job_last_row;
      out.out_pixel <= {prod[0][bb4_pkg::RCP_SHIFT +: bb4_pkg::CH_W],
                        prod[1][bb4_pkg::RCP_SHIFT +: bb4_pkg::CH_W],
                        prod[2][bb4_pkg::RCP_SHIFT +: bb4_pkg::CH_W], 8'hFF};
      out.end_of_run   <= st_eor;
      out.end_of_frame <= st_eof;
    end
  end

endmodule

// ===== rtl/box_blur_4x4_clipped.sv =====
// Top level of the streaming 4x4 clipped box blur.
// Pixels enter in raster order, one per cycle while the queue has room,
// followed by one padding row of frame_width items; results leave in raster
// order one row and one column behind, two results for the last item of each
// row. The back end delivers one result per cycle while the receiver is
// ready, so a row-end item occupies it for two results. A result passes the
// front-end stage register, the queue, the window, the sum stage and the
// output register. The row store is three RAM banks of MAX_WIDTH entries,
// read for all three older rows and written in the same cycle; it is not
// cleared after reset, and frame_width and frame_height may be written only
// while the block is idle.
module box_blur_4x4_clipped (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb4_pkg::CFG_W-1:0]     cfg_data,
  bb4_in_if.sink                        in,
  bb4_out_if.source                     out
);

  logic                      push;
  bb4_pkg::entry_t           push_data;
  logic                      pop;
  bb4_pkg::entry_t           pop_data;
  logic                      nonempty;
  logic [bb4_pkg::LVL_W-1:0] level;

  bb4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in),
    .level     (level),
    .push      (push),
    .push_data (push_data)
  );

  bb4_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty),
    .level     (level)
  );

  bb4_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .nonempty (nonempty),
    .pop      (pop),
    .out      (out)
  );

endmodule

// ===== rtl/bb4_checker.sv =====
// Port-level checks of the blur, attached to the top level.
module bb4_port_props (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        end_of_run,
  input logic        end_of_frame
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request right after reset");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pixel[7:0] == 8'hFF)
    else $error("alpha byte is not opaque");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_run)
    else $error("frame end without run end");

endmodule

bind box_blur_4x4_clipped bb4_port_props u_bb4_port_props (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .out_pixel    (out.out_pixel),
  .end_of_run   (out.end_of_run),
  .end_of_frame (out.end_of_frame)
);

// ===== verif/bb4_checker.sv =====
// Checker for the box blur: predicts blurred pixels from accepted requests and compares them.
module bb4_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb4_pkg::CFG_W-1:0]     cfg_data,
  bb4_in_if                             in_mon,
  bb4_out_if                            out_mon,
  output int                            errors,
  output int                            pending,
  output int                            results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pixel;
    logic        run_end;
    logic        frame_end;
  } blur_result_t;

  blur_result_t   blur_q[$];
  logic [bb4_pkg::PIX_W-1:0] line_mem [0:3*bb4_pkg::MAX_WIDTH-1];
  logic [bb4_pkg::PIX_W-1:0] win [0:15];
  int             col_pos;
  int             row_pos;
  logic [bb4_pkg::CFG_W-1:0] width_reg;
  logic [bb4_pkg::CFG_W-1:0] height_reg;

  function automatic int clamp_dim(input int v, input int hi);
    return (v < 2) ? 2 : ((v > hi) ? hi : v);
  endfunction

  // Average over window ages 0..max_age, dropping columns and rows outside the frame.
  function automatic logic [31:0] blurred(input int c, input int r, input int w,
                                          input int h, input int max_age);
    int rs, gs, bs, cnt, d;
    logic [bb4_pkg::PIX_W-1:0] p;
    logic [7:0] ro, go, bo;
    rs = 0; gs = 0; bs = 0; cnt = 0;
    for (int a = 0; a <= max_age; a++) begin
      if (a <= c && c - a < w) begin
        for (int k = 0; k < 4; k++) begin
          if (r + k >= 3 && r + k - 3 < h) begin
            p = win[a*4 + k];
            rs += p[23:16];
            gs += p[15:8];
            bs += p[7:0];
            cnt++;
          end
        end
      end
    end
    d = 5 * cnt + 1;
    ro = 8'((5 * rs) / d);
    go = 8'((5 * gs) / d);
    bo = 8'((5 * bs) / d);
    return {ro, go, bo, 8'hFF};
  endfunction

  task automatic take_pixel(input logic [31:0] pix);
    int w, h, c, r;
    logic [bb4_pkg::PIX_W-1:0] cur;
    bit left, row_end;
    blur_result_t e;
    w = clamp_dim(int'(width_reg), bb4_pkg::MAX_WIDTH);
    h = clamp_dim(int'(height_reg), bb4_pkg::MAX_HEIGHT);
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h;
    cur = (r < h) ? pix[31:8] : '0;
    for (int i = 12; i > 0; i--) win[i+3] = win[i-1];
    win[0] = line_mem[(r % 3) * bb4_pkg::MAX_WIDTH + c];
    win[1] = line_mem[((r + 1) % 3) * bb4_pkg::MAX_WIDTH + c];
    win[2] = line_mem[((r + 2) % 3) * bb4_pkg::MAX_WIDTH + c];
    win[3] = cur;
    if (r < h) line_mem[(r % 3) * bb4_pkg::MAX_WIDTH + c] = cur;
    left = (r >= 1) && (c >= 1);
    row_end = (r >= 1) && (c == w - 1);
    if (left) begin
      e.pixel = blurred(c, r, w, h, 3);
      e.run_end = !row_end;
      e.frame_end = 1'b0;
      blur_q.push_back(e);
    end
    if (row_end) begin
      e.pixel = blurred(c, r, w, h, 2);
      e.run_end = 1'b1;
      e.frame_end = (r == h);
      blur_q.push_back(e);
    end
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    blur_result_t e;
    if (rst) begin
      for (int i = 0; i < 3 * bb4_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
      for (int i = 0; i < 16; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = bb4_pkg::CFG_W'(640);
      height_reg = bb4_pkg::CFG_W'(480);
      blur_q.delete();
      errors = 0;
      results = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bb4_pkg::REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == bb4_pkg::REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        results++;
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected result: got pixel %h run_end %b frame_end %b", $time,
                   out_mon.out_pixel, out_mon.end_of_run, out_mon.end_of_frame);
          errors++;
        end else begin
          e = blur_q.pop_front();
          if (e.pixel !== out_mon.out_pixel) begin
            $display("%0t: out_pixel mismatch: expected %h, got %h", $time, e.pixel,
                     out_mon.out_pixel);
            errors++;
          end
          if (e.run_end !== out_mon.end_of_run) begin
            $display("%0t: end_of_run mismatch: expected %b, got %b", $time, e.run_end,
                     out_mon.end_of_run);
            errors++;
          end
          if (e.frame_end !== out_mon.end_of_frame) begin
            $display("%0t: end_of_frame mismatch: expected %b, got %b", $time, e.frame_end,
                     out_mon.end_of_frame);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) take_pixel(in_mon.in_pixel);
    end
    pending = blur_q.size();
  end

endmodule

// ===== verif/tb_box_blur_4x4_clipped.sv =====
// Top of the box blur testbench: clock, reset, frame stimulus, register writes and verdict.
module tb_box_blur_4x4_clipped;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [bb4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bb4_pkg::CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;
  int                   results;
  int                   pixels_sent;
  int                   frames_sent;
  int                   idle_cycles;
  int                   max_w;
  int                   max_h;
  bit                   calm_in;
  bit                   calm_out;
  int                   out_stall;

  bb4_in_if  in_if ();
  bb4_out_if out_if ();

  box_blur_4x4_clipped i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in       (in_if),
    .out      (out_if)
  );

  bb4_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .errors   (errors),
    .pending  (pending),
    .results  (results)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int eff_dim(input int v, input int hi);
    return (v < 2) ? 2 : ((v > hi) ? hi : v);
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Receiver stalls, with calm stretches where results are taken every cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      calm_out = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 99) < 15) begin
        out_stall = gap_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request accepted for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [31:0] pix, input logic pad);
    if (!calm_in && $urandom_range(0, 99) < 20) begin
      in_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_pixel <= pix;
    in_if.is_pad <= pad;
    do @(posedge clk); while (!in_if.ready);
    pixels_sent++;
    if ($urandom_range(0, 149) == 0) calm_in = !calm_in;
  endtask

  // Registers change only once every predicted result has drained.
  task automatic set_frame(input logic [bb4_pkg::CFG_W-1:0] wv,
                           input logic [bb4_pkg::CFG_W-1:0] hv);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bb4_pkg::REG_FRAME_WIDTH;
    cfg_data <= wv;
    @(posedge clk);
    cfg_index <= bb4_pkg::REG_FRAME_HEIGHT;
    cfg_data <= hv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One frame plus its padding row; fill 0 is random, 1 all ones, 2 all zeros.
  // A few padding flags disagree with the position on purpose.
  task automatic send_frame(input int w, input int h, input int fill, input bit bad_pad);
    logic [31:0] pix;
    logic        pad;
    for (int r = 0; r <= h; r++) begin
      for (int c = 0; c < w; c++) begin
        pix = (fill == 1) ? '1 : ((fill == 2) ? '0 : $urandom);
        pad = (r == h);
        if (bad_pad && $urandom_range(0, 19) == 0) pad = !pad;
        send_pixel(pix, pad);
      end
    end
    frames_sent++;
    if (w > max_w) max_w = w;
    if (h > max_h) max_h = h;
  endtask

  task automatic frame_with_regs(input int wv, input int hv, input int fill, input bit bad_pad);
    set_frame(bb4_pkg::CFG_W'(wv), bb4_pkg::CFG_W'(hv));
    send_frame(eff_dim(wv, bb4_pkg::MAX_WIDTH), eff_dim(hv, bb4_pkg::MAX_HEIGHT), fill,
               bad_pad);
  endtask

  initial begin
    int wv, hv;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bb4_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.in_pixel = '0;
    in_if.is_pad = 1'b0;
    pixels_sent = 0;
    frames_sent = 0;
    max_w = 0;
    max_h = 0;
    calm_in = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturated and empty frames, registers below the legal range.
    frame_with_regs(2, 2, 1, 1'b0);
    frame_with_regs(0, 1, 2, 1'b0);
    frame_with_regs(1, 3, 0, 1'b1);

    while (pixels_sent < 1000) begin
      wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
      frame_with_regs(wv, hv, ($urandom_range(0, 9) == 0) ? 1 : 0, $urandom_range(0, 3) == 0);
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d frames, %0d input requests and %0d blurred results,", frames_sent,
             pixels_sent, results);
    $display("with frames up to %0d pixels wide and %0d rows high.", max_w, max_h);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
